// File: sv/dasp_pkg.sv
// Shared constants for the disparity arg-min core with sub-pixel refinement.
// Field widths, configuration register indexes and the disparity range.
// No dependencies.
package dasp_pkg;

	localparam int COST_W     = 16;
	localparam int FRAC_W     = 8;
	localparam int MAX_DISP   = 128;
	localparam int IDX_W      = 7;
	localparam int NDISP_W    = 8;
	localparam int THR_W      = 18;
	localparam int FIXED_W    = 15;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 18;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 24;

	localparam logic [CFG_ADDR_W-1:0] REG_NUM_DISP = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_FLAT_THR = 1'b1;

endpackage

// File: sv/disparity_argmin_subpixel_core.sv
// Winner-take-all disparity search with parabolic sub-pixel refinement.
// Uses dasp_pkg for widths and register indexes; contains the sequencer and
// the shared subtract-and-compare unit of the serial divider.
//
// Usage: one pixel's costs arrive on the s_axis channel, one cost per
// transfer, for disparities 0 to num_disparities-1 (num_disparities taken
// within 2 to 128). After the last cost of a pixel the block forms the
// parabola terms and, when refinement applies, runs the restoring divider,
// one quotient bit per cycle through a single subtractor. The result leaves
// on the m_axis channel from an output register; costs of the next pixel
// are taken while that result waits, and only the last cost of the next
// pixel is held back until the previous result is transferred.
// The core takes no cost while the divider runs.
// The configuration port writes num_disparities (index 0) and
// flat_threshold (index 1); write them only while idle.
// Reset is asynchronous and active low; it clears the search state, sets
// num_disparities to 64 and flat_threshold to 0, and empties the output.
module disparity_argmin_subpixel_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dasp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [dasp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [dasp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [15:0] cost
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [14:0] disparity_fixed, [21:15] integer_disparity, [22] refined, [23] zero
	output logic [dasp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	localparam logic [1:0] ST_COLLECT = 2'd0;
	localparam logic [1:0] ST_PREP    = 2'd1;
	localparam logic [1:0] ST_DIV     = 2'd2;

	localparam int CW   = dasp_pkg::COST_W;
	localparam int FW   = dasp_pkg::FRAC_W;
	localparam int IW   = dasp_pkg::IDX_W;
	localparam int NW   = dasp_pkg::NDISP_W;
	localparam int TW   = dasp_pkg::THR_W;
	localparam int XW   = dasp_pkg::FIXED_W;
	localparam int REMW = CW + FW;
	localparam int DVW  = TW + FW;

	logic [1:0]          st_q;
	logic [NW-1:0]       num_disp_q;
	logic [TW-1:0]       flat_thr_q;

	logic [IW-1:0]       position_q;
	logic [CW-1:0]       min_cost_q;
	logic [IW-1:0]       best_idx_q;
	logic [CW-1:0]       cost_before_q;
	logic [CW-1:0]       cost_after_q;
	logic                after_pend_q;
	logic [CW-1:0]       prev_cost_q;

	logic [REMW-1:0]     rem_q;
	logic [DVW-1:0]      dv_q;
	logic [FW:0]         quo_q;
	logic [3:0]          cnt_q;
	logic                neg_q;

	logic                out_valid_q;
	logic [XW-1:0]       out_fixed_q;
	logic [IW-1:0]       out_idx_q;
	logic                out_refined_q;

	logic [NW-1:0]       n_eff;
	logic                last_pos;
	logic                in_xfer;
	logic [CW-1:0]       cost_in;

	logic signed [CW+2:0] dsum;
	logic [TW-1:0]       denom;
	logic                denom_pos;
	logic                interior;
	logic                do_refine;
	logic signed [CW+1:0] num_diff;
	logic [CW-1:0]       num_mag;
	logic [DVW:0]        sub_diff;
	logic                sub_ok;
	logic [XW-1:0]       base_fixed;
	logic [FW:0]         quo_final;
	logic [XW-1:0]       refined_fixed;

	always_comb begin
		if (num_disp_q < NW'(2)) begin
			n_eff = NW'(2);
		end else if (num_disp_q > NW'(dasp_pkg::MAX_DISP)) begin
			n_eff = NW'(dasp_pkg::MAX_DISP);
		end else begin
			n_eff = num_disp_q;
		end
	end

	assign last_pos      = ({1'b0, position_q} + NW'(1)) >= n_eff;
	assign s_axis_tready = (st_q == ST_COLLECT) && !(last_pos && out_valid_q);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cost_in       = s_axis_tdata[CW-1:0];

	assign dsum = $signed({3'b000, cost_before_q}) + $signed({3'b000, cost_after_q})
	            - $signed({2'b00, min_cost_q, 1'b0});
	assign denom_pos = !dsum[CW+2] && (dsum != '0);
	assign denom     = {dsum[TW-2:0], 1'b0};
	assign interior  = (best_idx_q != '0) && (({1'b0, best_idx_q} + NW'(1)) < n_eff);
	assign do_refine = interior && denom_pos && (denom > flat_thr_q);
	assign num_diff  = $signed({2'b00, cost_before_q}) - $signed({2'b00, cost_after_q});
	assign num_mag   = num_diff[CW+1] ? CW'(-num_diff) : num_diff[CW-1:0];

	assign sub_diff  = {1'b0, {(DVW-REMW){1'b0}}, rem_q} - {1'b0, dv_q};
	assign sub_ok    = !sub_diff[DVW];

	assign base_fixed = {best_idx_q, {FW{1'b0}}};
	always_comb begin
		if (cnt_q == 4'd0) begin
			quo_final = sub_ok ? {1'b1, {FW{1'b0}}} : '0;
		end else begin
			quo_final = {quo_q[FW-1:0], sub_ok};
		end
	end
	assign refined_fixed = neg_q ? base_fixed - XW'(quo_final) : base_fixed + XW'(quo_final);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_disp_q <= NW'(64);
			flat_thr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				dasp_pkg::REG_NUM_DISP: num_disp_q <= cfg_wdata[NW-1:0];
				dasp_pkg::REG_FLAT_THR: flat_thr_q <= cfg_wdata[TW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_COLLECT;
			position_q    <= '0;
			min_cost_q    <= '0;
			best_idx_q    <= '0;
			cost_before_q <= '0;
			cost_after_q  <= '0;
			after_pend_q  <= 1'b0;
			prev_cost_q   <= '0;
			out_valid_q   <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_COLLECT: begin
					if (in_xfer) begin
						if (position_q == '0) begin
							min_cost_q    <= cost_in;
							best_idx_q    <= '0;
							cost_before_q <= '0;
							cost_after_q  <= '0;
							after_pend_q  <= 1'b1;
						end else begin
							if (after_pend_q) begin
								cost_after_q <= cost_in;
								after_pend_q <= 1'b0;
							end
							if (cost_in < min_cost_q) begin
								min_cost_q    <= cost_in;
								best_idx_q    <= position_q;
								cost_before_q <= prev_cost_q;
								after_pend_q  <= 1'b1;
							end
						end
						prev_cost_q <= cost_in;
						if (last_pos) begin
							position_q <= '0;
							st_q       <= ST_PREP;
						end else begin
							position_q <= position_q + IW'(1);
						end
					end
				end
				ST_PREP: begin
					if (do_refine) begin
						cnt_q <= '0;
						st_q  <= ST_DIV;
					end else begin
						out_valid_q <= 1'b1;
						st_q        <= ST_COLLECT;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if ((cnt_q == 4'd0 && sub_ok) || cnt_q == 4'(FW)) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_COLLECT;
					end
				end
				default: st_q <= ST_COLLECT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_PREP: begin
				rem_q         <= {num_mag, {FW{1'b0}}};
				dv_q          <= {denom, {FW{1'b0}}};
				quo_q         <= '0;
				neg_q         <= num_diff[CW+1];
				out_fixed_q   <= base_fixed;
				out_idx_q     <= best_idx_q;
				out_refined_q <= 1'b0;
			end
			ST_DIV: begin
				if (sub_ok) begin
					rem_q <= sub_diff[REMW-1:0];
				end
				dv_q  <= {1'b0, dv_q[DVW-1:1]};
				quo_q <= quo_final;
				if ((cnt_q == 4'd0 && sub_ok) || cnt_q == 4'(FW)) begin
					out_fixed_q   <= refined_fixed;
					out_refined_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_refined_q, out_idx_q, out_fixed_q};

	ready_only_collecting: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> st_q == ST_COLLECT)
		else $error("cost accepted outside the collect phase");

	no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_COLLECT |-> !out_valid_q)
		else $error("result register occupied while a pixel is being resolved");

	result_from_sequencer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q) == ST_PREP || $past(st_q) == ST_DIV)
		else $error("result appeared outside the resolve phase");

	unrefined_is_integer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_refined_q |-> out_fixed_q == {out_idx_q, {FW{1'b0}}})
		else $error("unrefined result carries a fraction");

	divider_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> cnt_q <= 4'(FW))
		else $error("divider ran past its last quotient bit");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for disparity_argmin_subpixel_core.
// Drives cost streams and register writes, predicts each pixel's result in a
// scoreboard class and compares every output transfer; depends on dasp_pkg.
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_COSTS = 1650;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;
	localparam longint ONE_FX = longint'(1) <<< dasp_pkg::FRAC_W;

	typedef struct {
		logic [dasp_pkg::FIXED_W-1:0] fixed;
		logic [dasp_pkg::IDX_W-1:0]   index;
		logic                         refined;
	} disp_result_t;

	class disparity_scoreboard;
		logic [dasp_pkg::NDISP_W-1:0] num_disp;
		logic [dasp_pkg::THR_W-1:0]   flat_thr;
		int                           position;
		int                           best_index;
		logic [dasp_pkg::COST_W-1:0]  min_cost;
		logic [dasp_pkg::COST_W-1:0]  cost_lo;
		logic [dasp_pkg::COST_W-1:0]  cost_hi;
		logic [dasp_pkg::COST_W-1:0]  prev_cost;
		bit                           right_pending;
		disp_result_t                 expected_q[$];
		int                           errors;

		function new();
			num_disp = 64;
			flat_thr = '0;
			position = 0;
			best_index = 0;
			min_cost = '0;
			cost_lo = '0;
			cost_hi = '0;
			prev_cost = '0;
			right_pending = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [dasp_pkg::CFG_ADDR_W-1:0] addr,
				logic [dasp_pkg::CFG_DATA_W-1:0] data);
			if (addr == dasp_pkg::REG_NUM_DISP) begin
				num_disp = data[dasp_pkg::NDISP_W-1:0];
			end else if (addr == dasp_pkg::REG_FLAT_THR) begin
				flat_thr = data[dasp_pkg::THR_W-1:0];
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_cost(logic [dasp_pkg::COST_W-1:0] c);
			int n;
			longint c1, c2, c3, denom, mag, delta, fixed_val;
			disp_result_t r;
			n = num_disp;
			if (n < 2) n = 2;
			if (n > dasp_pkg::MAX_DISP) n = dasp_pkg::MAX_DISP;
			if (position == 0) begin
				min_cost = c;
				best_index = 0;
				cost_lo = '0;
				cost_hi = '0;
				right_pending = 1;
			end else begin
				if (right_pending) begin
					cost_hi = c;
					right_pending = 0;
				end
				if (c < min_cost) begin
					min_cost = c;
					best_index = position;
					cost_lo = prev_cost;
					right_pending = 1;
				end
			end
			prev_cost = c;
			if (position + 1 < n) begin
				position++;
				return;
			end
			position = 0;
			fixed_val = longint'(best_index) * ONE_FX;
			r.refined = 1'b0;
			if (best_index > 0 && best_index < n - 1) begin
				c1 = longint'(cost_lo);
				c2 = longint'(min_cost);
				c3 = longint'(cost_hi);
				denom = 2 * (c1 - 2 * c2 + c3);
				mag = (denom < 0) ? -denom : denom;
				if (mag > longint'(flat_thr) && denom != 0) begin
					delta = ((c1 - c3) * ONE_FX) / denom;
					if (delta > ONE_FX) delta = ONE_FX;
					if (delta < -ONE_FX) delta = -ONE_FX;
					fixed_val += delta;
					r.refined = 1'b1;
				end
			end
			if (fixed_val < 0) fixed_val = 0;
			r.fixed = fixed_val[dasp_pkg::FIXED_W-1:0];
			r.index = best_index[dasp_pkg::IDX_W-1:0];
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [dasp_pkg::OUT_TDATA_W-1:0] tdata);
			disp_result_t want;
			if (expected_q.size() == 0) begin
				$error("Unexpected result transfer, tdata %h.", tdata);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (tdata[dasp_pkg::FIXED_W-1:0] !== want.fixed) begin
				$error("disparity_fixed: expected %0d, actual %0d", want.fixed,
					tdata[dasp_pkg::FIXED_W-1:0]);
				errors++;
			end
			if (tdata[dasp_pkg::FIXED_W +: dasp_pkg::IDX_W] !== want.index) begin
				$error("integer_disparity: expected %0d, actual %0d", want.index,
					tdata[dasp_pkg::FIXED_W +: dasp_pkg::IDX_W]);
				errors++;
			end
			if (tdata[dasp_pkg::FIXED_W+dasp_pkg::IDX_W] !== want.refined) begin
				$error("refined: expected %0d, actual %0d", want.refined,
					tdata[dasp_pkg::FIXED_W+dasp_pkg::IDX_W]);
				errors++;
			end
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [dasp_pkg::CFG_ADDR_W-1:0]   cfg_addr = '0;
	logic [dasp_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
	logic                              s_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [dasp_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
	logic                              m_axis_tvalid;
	logic                              m_tready = 1'b0;
	logic [dasp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

	disparity_scoreboard sb;
	bit steady = 0;
	bit hold_req = 0;
	bit hold_done = 0;
	int hold_left = 0;
	int cycles = 0;
	int costs_sent = 0;

	disparity_argmin_subpixel_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(0, 99) >= 10);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_axis_tready) sb.note_cost(s_tdata);
			if (m_axis_tvalid && m_tready) sb.check_result(m_axis_tdata);
		end
	end

	task automatic send_cost(input logic [dasp_pkg::COST_W-1:0] c);
		if (!steady) begin
			while ($urandom_range(0, 99) < 10) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!s_axis_tready);
		costs_sent++;
	endtask

	task automatic write_reg(input logic [dasp_pkg::CFG_ADDR_W-1:0] addr, input int data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data[dasp_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		sb.write_reg(addr, data[dasp_pkg::CFG_DATA_W-1:0]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixel(input int n);
		int shape, center, slope, base, level, value;
		shape = $urandom_range(0, 9);
		center = $urandom_range(0, n - 1);
		slope = $urandom_range(1, 3000);
		base = $urandom_range(0, 30000);
		level = $urandom_range(0, 65535);
		for (int i = 0; i < n; i++) begin
			if (shape < 4) begin
				value = $urandom_range(0, 65535);
			end else if (shape < 8) begin
				value = base + slope * ((i > center) ? i - center : center - i)
					+ $urandom_range(0, 600);
				if (value > 65535) value = 65535;
			end else if (shape == 8) begin
				value = $urandom_range(0, 3);
			end else begin
				value = level;
			end
			send_cost(value[dasp_pkg::COST_W-1:0]);
		end
	endtask

	initial begin
		int cfg_n, eff_n, thr, pixels, phase;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pixels at the reset configuration.
		repeat (2) send_pixel(64);
		drain();

		// Register values below the minimum act as two costs per pixel.
		write_reg(dasp_pkg::REG_FLAT_THR, 0);
		write_reg(dasp_pkg::REG_NUM_DISP, 0);
		send_cost(16'd0);
		send_cost(16'hFFFF);
		send_cost(16'hFFFF);
		send_cost(16'd0);
		drain();
		write_reg(dasp_pkg::REG_NUM_DISP, 1);
		send_cost(16'd7);
		send_cost(16'd7);
		drain();
		write_reg(dasp_pkg::REG_NUM_DISP, 3);
		send_cost(16'd5);
		send_cost(16'd1);
		send_cost(16'd9);
		send_cost(16'hFFFF);
		send_cost(16'd0);
		send_cost(16'hFFFF);
		drain();
		// A parabola whose denominator does not exceed the threshold is flat.
		write_reg(dasp_pkg::REG_FLAT_THR, 262140);
		send_cost(16'hFFFF);
		send_cost(16'd0);
		send_cost(16'hFFFF);
		drain();
		write_reg(dasp_pkg::REG_FLAT_THR, 262143);
		send_cost(16'hFFFE);
		send_cost(16'd0);
		send_cost(16'hFFFF);
		drain();
		// Shrinking the pixel length mid-pixel ends the pixel on the next cost.
		write_reg(dasp_pkg::REG_FLAT_THR, 0);
		write_reg(dasp_pkg::REG_NUM_DISP, 5);
		send_cost(16'd9);
		send_cost(16'd4);
		send_cost(16'd8);
		drain();
		write_reg(dasp_pkg::REG_NUM_DISP, 2);
		send_cost(16'd6);
		drain();

		costs_sent = 0;
		phase = 0;
		while (costs_sent < RANDOM_COSTS) begin
			case ($urandom_range(0, 19))
				0: cfg_n = $urandom_range(0, 1);
				1: cfg_n = 128;
				2: cfg_n = $urandom_range(129, 255);
				3, 4, 5: cfg_n = $urandom_range(17, 64);
				default: cfg_n = $urandom_range(2, 16);
			endcase
			case ($urandom_range(0, 9))
				0: thr = 0;
				1: thr = 262143;
				2: thr = $urandom & 32'h3FFFF;
				default: thr = $urandom_range(0, 4096);
			endcase
			eff_n = (cfg_n < 2) ? 2 :
				((cfg_n > dasp_pkg::MAX_DISP) ? dasp_pkg::MAX_DISP : cfg_n);
			pixels = (eff_n > 64) ? $urandom_range(1, 2) : $urandom_range(60, 160) / eff_n;
			if (pixels < 1) pixels = 1;
			if (phase == 5 && pixels < 2) pixels = 2;
			write_reg(dasp_pkg::REG_NUM_DISP, cfg_n);
			write_reg(dasp_pkg::REG_FLAT_THR, thr);
			steady = (phase == 3);
			if (phase == 5) hold_req = 1;
			repeat (pixels) send_pixel(eff_n);
			drain();
			steady = 0;
			phase++;
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
